FILE: sv/gad_pkg.sv
// Shared types, constants and helper functions for the gamepad activity detector.
// No dependencies; every other file in the project depends on this package.
package gad_pkg;

    localparam int SLOT_FIELD_W = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_STEP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STICK_STEP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_GAP   = 2'd2;

    localparam logic [7:0]  TRIG_STEP_RST    = 8'd128;
    localparam logic [15:0] STICK_STEP_RST   = 16'd6554;
    localparam logic [15:0] REPORT_GAP_RST   = 16'd1000;

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] slot;
        logic                    probe_pass;
        logic                    present;
        logic [15:0]             buttons;
        logic [7:0]              left_trigger;
        logic [7:0]              right_trigger;
        logic signed [15:0]      left_stick_x;
        logic signed [15:0]      left_stick_y;
        logic signed [15:0]      right_stick_x;
        logic signed [15:0]      right_stick_y;
        logic [31:0]             now_ms;
    } t_sample;

    typedef struct packed {
        logic activity;
        logic report;
        logic slot_connected;
    } t_result;

    // Per-slot record kept in the slot memory.
    typedef struct packed {
        logic        connected;
        logic        known;
        logic [15:0] buttons;
        logic [15:0] triggers;  // left in 7:0, right in 15:8
        logic [63:0] sticks;    // LX 15:0, LY 31:16, RX 47:32, RY 63:48
    } t_slot_rec;

    typedef struct packed {
        logic [7:0]  trig_step;
        logic [15:0] stick_step;
        logic [15:0] report_gap;
    } t_cfg;

    typedef struct packed {
        t_slot_rec new_rec;
        logic      write;
        logic      fire_report;
        t_result   result;
    } t_eval;

    function automatic logic [7:0] trig_absdiff(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] d;
        logic [8:0] m;
        d = {1'b0, a} - {1'b0, b};
        m = d[8] ? (9'd0 - d) : d;
        return m[7:0];
    endfunction

    function automatic logic [15:0] axis_absdiff(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] d;
        logic [16:0] m;
        d = {a[15], a} - {b[15], b};
        m = d[16] ? (17'd0 - d) : d;
        return m[15:0];
    endfunction

endpackage

FILE: sv/gad_sample_if.sv
// Input channel carrying one controller sample per transfer.
// Depends on gad_pkg for the payload type.
interface gad_sample_if;
    logic             valid;
    logic             ready;
    gad_pkg::t_sample payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/gad_result_if.sv
// Output channel carrying one activity result per transfer.
// Depends on gad_pkg for the payload type.
interface gad_result_if;
    logic             valid;
    logic             ready;
    gad_pkg::t_result payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/gamepad_activity_detector.sv
// Gamepad activity detector: top level with the sample pipeline, the
// configuration and report registers and the output register.
// Depends on gad_pkg, gad_sample_if, gad_result_if, gad_slot_mem and gad_eval.
// A sample's result passes the evaluation stage, then the output register.
// Throughput: one sample per cycle unless the output stalls; the slot memory is
// read on transfer, written back when the result is registered, with same-slot forwarding.
// Reset: all slots read as disconnected, unknown and zeroed at once through
// per-entry valid bits (no clearing pass); steps and gap return to defaults.
module gamepad_activity_detector #(
    parameter int SLOTS = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gad_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gad_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    gad_sample_if.sink                      i_sample,
    gad_result_if.source                    o_result
);
    import gad_pkg::*;

    // Memory address width follows the slot count; the slot field is fixed
    // at two bits, so the field is widened before the address is cut from it.
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int EXT_W  = (SLOT_W > SLOT_FIELD_W) ? SLOT_W : SLOT_FIELD_W;

    // Configuration registers.
    t_cfg        r_cfg;

    // Global report state.
    logic [31:0] r_last_report;
    logic        r_ever_reported;

    // Evaluation stage: sample whose record is being read this cycle.
    logic        r_s1_valid;
    t_sample     r_s1_sample;

    // Output register.
    logic        r_out_valid;
    t_result     r_out;

    logic              in_xfer;
    logic              out_free;
    logic              s1_fire;
    logic [EXT_W-1:0]  in_slot_ext;
    logic [EXT_W-1:0]  s1_slot_ext;
    t_slot_rec         rd_rec;
    t_eval             eval;

    // The output register frees up when empty or when its result is taken;
    // the evaluation stage may then move forward and a new sample may enter.
    assign out_free         = !r_out_valid || o_result.ready;
    assign s1_fire          = r_s1_valid && out_free;
    assign i_sample.ready   = !r_s1_valid || out_free;
    assign in_xfer          = i_sample.valid && i_sample.ready;
    assign in_slot_ext      = EXT_W'(i_sample.payload.slot);
    assign s1_slot_ext      = EXT_W'(r_s1_sample.slot);

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

    // Configuration writes; an index past the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trig_step    <= TRIG_STEP_RST;
            r_cfg.stick_step   <= STICK_STEP_RST;
            r_cfg.report_gap   <= REPORT_GAP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TRIG_STEP:    r_cfg.trig_step    <= i_cfg_data[7:0];
                CFG_STICK_STEP:   r_cfg.stick_step   <= i_cfg_data;
                CFG_REPORT_GAP:   r_cfg.report_gap   <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // The slot record is read on the transfer edge, so it is ready in the
    // evaluation stage on the next cycle. The write back happens when the
    // evaluated result moves into the output register.
    gad_slot_mem #(
        .SLOTS  (SLOTS),
        .ADDR_W (SLOT_W)
    ) u_slot_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_xfer),
        .i_rd_addr (in_slot_ext[SLOT_W-1:0]),
        .i_wr_en   (s1_fire && eval.write),
        .i_wr_addr (s1_slot_ext[SLOT_W-1:0]),
        .i_wr_data (eval.new_rec),
        .o_rd_rec  (rd_rec)
    );

    gad_eval #(
        .SLOTS (SLOTS)
    ) u_eval (
        .i_sample        (r_s1_sample),
        .i_rec           (rd_rec),
        .i_cfg           (r_cfg),
        .i_last_report   (r_last_report),
        .i_ever_reported (r_ever_reported),
        .o_eval          (eval)
    );

    // Pipeline control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_ever_reported <= 1'b0;
            r_last_report   <= '0;
        end else begin
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            // Report timing is committed only when the result is registered,
            // so a stalled sample never advances the report clock twice.
            if (s1_fire && eval.fire_report) begin
                r_ever_reported <= 1'b1;
                r_last_report   <= r_s1_sample.now_ms;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_sample <= i_sample.payload;
        end
        if (s1_fire) begin
            r_out <= eval.result;
        end
    end

    a_report_needs_activity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out.report || r_out.activity))
        else $error("report raised without activity");

    a_activity_needs_connect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out.activity || r_out.slot_connected))
        else $error("activity on a slot that is not connected");

    a_xfer_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_s1_valid)
        else $error("accepted sample did not reach the evaluation stage");

    a_report_marks_ever: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && eval.fire_report) |=> (r_ever_reported
            && (r_last_report == $past(r_s1_sample.now_ms))))
        else $error("report time not recorded");

    a_empty_stage_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> i_sample.ready)
        else $error("empty pipeline refused a sample");

endmodule

FILE: sv/gad_slot_mem.sv
// Per-slot record memory with registered read, entry valid bits
// and write-to-read forwarding. Depends on gad_pkg for the record type.
module gad_slot_mem #(
    parameter int SLOTS = 4,
    parameter int ADDR_W = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [ADDR_W-1:0]  i_rd_addr,
    input  logic               i_wr_en,
    input  logic [ADDR_W-1:0]  i_wr_addr,
    input  gad_pkg::t_slot_rec i_wr_data,
    output gad_pkg::t_slot_rec o_rd_rec
);
    import gad_pkg::*;

    t_slot_rec        mem [SLOTS];
    logic [SLOTS-1:0] r_valid;
    t_slot_rec        r_rd_data;
    logic             r_rd_valid;
    logic             r_fwd_hit;
    t_slot_rec        r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
                r_fwd_hit  <= i_wr_en && (i_wr_addr == i_rd_addr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_data <= i_wr_data;
        end
    end

    // A write landing on the same edge as the read wins; a never-written
    // entry reads as the all-zero reset record.
    always_comb begin
        priority if (r_fwd_hit) begin
            o_rd_rec = r_fwd_data;
        end else if (r_rd_valid) begin
            o_rd_rec = r_rd_data;
        end else begin
            o_rd_rec = '0;
        end
    end

endmodule

FILE: sv/gad_eval.sv
// Per-sample evaluation: compares a sample against its slot record, builds the
// updated record and decides activity and report. Depends on gad_pkg.
module gad_eval #(
    parameter int SLOTS = 4
) (
    input  gad_pkg::t_sample   i_sample,
    input  gad_pkg::t_slot_rec i_rec,
    input  gad_pkg::t_cfg      i_cfg,
    input  logic [31:0]        i_last_report,
    input  logic               i_ever_reported,
    output gad_pkg::t_eval     o_eval
);
    import gad_pkg::*;

    logic        in_range;
    logic        examined;
    logic        moved;
    logic        gap_ok;
    logic [15:0] trig_now;
    logic [63:0] sticks_now;
    logic [31:0] elapsed;

    assign in_range   = 32'(i_sample.slot) < SLOTS;
    assign examined   = i_rec.connected | i_sample.probe_pass;
    assign trig_now   = {i_sample.right_trigger, i_sample.left_trigger};
    assign sticks_now = {i_sample.right_stick_y, i_sample.right_stick_x,
                         i_sample.left_stick_y, i_sample.left_stick_x};
    assign elapsed    = i_sample.now_ms - i_last_report;
    assign gap_ok     = !i_ever_reported || (elapsed >= {16'd0, i_cfg.report_gap});

    always_comb begin
        moved = (i_rec.buttons != i_sample.buttons);
        for (int t = 0; t < 2; t++) begin
            if (trig_absdiff(i_rec.triggers[8*t +: 8], trig_now[8*t +: 8])
                    >= i_cfg.trig_step) begin
                moved = 1'b1;
            end
        end
        for (int a = 0; a < 4; a++) begin
            if (axis_absdiff(i_rec.sticks[16*a +: 16], sticks_now[16*a +: 16])
                    >= i_cfg.stick_step) begin
                moved = 1'b1;
            end
        end
    end

    always_comb begin
        o_eval         = '0;
        o_eval.new_rec = i_rec;
        o_eval.write   = in_range;
        if (in_range && examined) begin
            if (!i_sample.present) begin
                o_eval.new_rec = '0;
            end else begin
                o_eval.new_rec.connected = 1'b1;
                if (!i_rec.known || moved) begin
                    o_eval.new_rec.known    = 1'b1;
                    o_eval.new_rec.buttons  = i_sample.buttons;
                    o_eval.new_rec.triggers = trig_now;
                    o_eval.new_rec.sticks   = sticks_now;
                end
                if (i_rec.known && moved) begin
                    o_eval.result.activity = 1'b1;
                    o_eval.fire_report     = gap_ok;
                    o_eval.result.report   = gap_ok;
                end
            end
        end
        o_eval.result.slot_connected = in_range & o_eval.new_rec.connected;
    end

endmodule
